/* rtl/tgzr_pkg.sv */
// Shared constants, codes and types for the touch gesture zone recognizer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package tgzr_pkg;

   // Panel geometry
   localparam int SCREEN_SIZE  = 466;
   localparam int INNER_RADIUS = 80;
   localparam int OUTER_RADIUS = 200;
   localparam int CENTER       = SCREEN_SIZE / 2;
   localparam int MAX_COORD    = SCREEN_SIZE - 1;
   localparam int INNER_SQ     = INNER_RADIUS * INNER_RADIUS;
   localparam int OUTER_SQ     = OUTER_RADIUS * OUTER_RADIUS;

   // Field widths
   localparam int RAW_W     = 12;
   localparam int COORD_W   = 9;
   localparam int OFS_W     = 11;  // signed offsets and travel
   localparam int SQ_W      = 2 * OFS_W;
   localparam int DIST_W    = 18;  // squared distance from center
   localparam int DISP_W    = 19;  // squared travel of a press
   localparam int STAMP_W   = 32;
   localparam int TIME_W    = 24;
   localparam int PIX_W     = 9;
   localparam int TAP_SQ_W  = 2 * PIX_W;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // Register reset values
   localparam int TAP_MAX_RST      = 300000;
   localparam int HOLD_TIME_RST    = 800000;
   localparam int SWIPE_MAX_RST    = 600000;
   localparam int REPEAT_WIN_RST   = 400000;
   localparam int DEBOUNCE_RST     = 50000;
   localparam int TAP_DISP_RST     = 15;
   localparam int SWIPE_MIN_RST    = 35;
   localparam int SWIPE_CROSS_RST  = 80;

   typedef enum logic [CODE_W-1:0] {
      GEST_TAP    = 3'd0,
      GEST_DOUBLE = 3'd1,
      GEST_LONG   = 3'd2,
      GEST_UP     = 3'd3,
      GEST_DOWN   = 3'd4,
      GEST_LEFT   = 3'd5,
      GEST_RIGHT  = 3'd6
   } gesture_type;

   typedef enum logic [CODE_W-1:0] {
      ZONE_CENTER  = 3'd0,
      ZONE_TOP     = 3'd1,
      ZONE_RIGHT   = 3'd2,
      ZONE_BOTTOM  = 3'd3,
      ZONE_LEFT    = 3'd4,
      ZONE_OUTSIDE = 3'd5
   } zone_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_MAX     = 3'd0,
      CSR_HOLD_TIME   = 3'd1,
      CSR_SWIPE_MAX   = 3'd2,
      CSR_REPEAT_WIN  = 3'd3,
      CSR_DEBOUNCE    = 3'd4,
      CSR_TAP_DISP    = 3'd5,
      CSR_SWIPE_MIN   = 3'd6,
      CSR_SWIPE_CROSS = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/tgzr_req_if.sv */
// Sample channel: valid/ready handshake with one poll sample as payload.
// Depends on tgzr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tgzr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           touched;
   logic [tgzr_pkg::RAW_W-1:0]     raw_x;
   logic [tgzr_pkg::RAW_W-1:0]     raw_y;
   logic [tgzr_pkg::STAMP_W-1:0]   stamp_us;

   modport source (output valid, touched, raw_x, raw_y, stamp_us, input ready);
   modport sink   (input valid, touched, raw_x, raw_y, stamp_us, output ready);
endinterface

`default_nettype wire

/* rtl/tgzr_rsp_if.sv */
// Gesture channel: valid/ready handshake carrying gesture and zone codes.
// Depends on tgzr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tgzr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tgzr_pkg::CODE_W-1:0]   gesture;
   logic [tgzr_pkg::CODE_W-1:0]   zone;

   modport source (output valid, gesture, zone, input ready);
   modport sink   (input valid, gesture, zone, output ready);
endinterface

`default_nettype wire

/* rtl/tgzr_zone.sv */
// Zone classifier: center, compass sector or outside for one panel point.
// Exact integer squared-distance and diagonal compares; uses tgzr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgzr_zone (
   input  logic [tgzr_pkg::COORD_W-1:0] pos_x,
   input  logic [tgzr_pkg::COORD_W-1:0] pos_y,
   output tgzr_pkg::zone_type           zone
);

   logic signed [tgzr_pkg::OFS_W-1:0] east;
   logic signed [tgzr_pkg::OFS_W-1:0] north;
   logic signed [tgzr_pkg::OFS_W-1:0] neg_east;
   logic signed [tgzr_pkg::OFS_W-1:0] neg_north;
   logic signed [tgzr_pkg::SQ_W-1:0]  east_sq;
   logic signed [tgzr_pkg::SQ_W-1:0]  north_sq;
   logic [tgzr_pkg::DIST_W-1:0]       dist_sq;

   assign east      = $signed({2'b00, pos_x}) - $signed(tgzr_pkg::OFS_W'(tgzr_pkg::CENTER));
   assign north     = $signed(tgzr_pkg::OFS_W'(tgzr_pkg::CENTER)) - $signed({2'b00, pos_y});
   assign neg_east  = -east;
   assign neg_north = -north;
   assign east_sq   = tgzr_pkg::SQ_W'(east) * tgzr_pkg::SQ_W'(east);
   assign north_sq  = tgzr_pkg::SQ_W'(north) * tgzr_pkg::SQ_W'(north);
   assign dist_sq   = tgzr_pkg::DIST_W'(east_sq) + tgzr_pkg::DIST_W'(north_sq);

   // Diagonals belong to the sector that starts there, going clockwise from top
   always_comb begin
      if (dist_sq < tgzr_pkg::DIST_W'(tgzr_pkg::INNER_SQ)) begin
         zone = tgzr_pkg::ZONE_CENTER;
      end else if (dist_sq > tgzr_pkg::DIST_W'(tgzr_pkg::OUTER_SQ)) begin
         zone = tgzr_pkg::ZONE_OUTSIDE;
      end else if (north > 0 && east >= neg_north && east < north) begin
         zone = tgzr_pkg::ZONE_TOP;
      end else if (east > 0 && north > neg_east && north <= east) begin
         zone = tgzr_pkg::ZONE_RIGHT;
      end else if (north < 0 && east > north && east <= neg_north) begin
         zone = tgzr_pkg::ZONE_BOTTOM;
      end else begin
         zone = tgzr_pkg::ZONE_LEFT;
      end
   end

endmodule

`default_nettype wire

/* rtl/touch_gesture_zone_recognizer_unit.sv */
// Top level of the touch gesture zone recognizer: sample register, press
// tracking, gesture decision, debounce and result register.
// Depends on tgzr_pkg, tgzr_req_if, tgzr_rsp_if and tgzr_zone.
//
//   channel  | direction | handshake        | payload
//   req      | in        | valid/ready      | touched, raw_x, raw_y, stamp_us
//   rsp      | out       | valid/ready      | gesture, zone
//   csr      | in        | csr_we           | csr_index, csr_data
//
// One sample per cycle unless a stalled result holds the sample register. A sample is
// clamped, rotated and zone-classified on the way into the sample register; the gesture
// decision is made from the sample register and registered in the result register.
// Reset clears press, tap and debounce tracking and loads register defaults.
// A stalled result only holds off the sample register; the req side keeps
// taking samples while the sample register is empty or moving.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_zone_recognizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   tgzr_req_if.sink                            req,
   tgzr_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [tgzr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tgzr_pkg::CSR_DAT_W-1:0]      csr_data
);

   // ---------------- configuration registers ----------------
   logic [tgzr_pkg::TIME_W-1:0]   tap_max_ff, hold_time_ff, swipe_max_ff;
   logic [tgzr_pkg::TIME_W-1:0]   repeat_win_ff, debounce_ff;
   logic [tgzr_pkg::TAP_SQ_W-1:0] tap_sq_ff;
   logic [tgzr_pkg::PIX_W-1:0]    swipe_min_ff, swipe_cross_ff;
   logic [tgzr_pkg::PIX_W-1:0]    csr_pix;

   assign csr_pix = csr_data[tgzr_pkg::PIX_W-1:0];

   // Displacement threshold is kept squared; only the square is ever compared
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_max_ff     <= tgzr_pkg::TIME_W'(tgzr_pkg::TAP_MAX_RST);
         hold_time_ff   <= tgzr_pkg::TIME_W'(tgzr_pkg::HOLD_TIME_RST);
         swipe_max_ff   <= tgzr_pkg::TIME_W'(tgzr_pkg::SWIPE_MAX_RST);
         repeat_win_ff  <= tgzr_pkg::TIME_W'(tgzr_pkg::REPEAT_WIN_RST);
         debounce_ff    <= tgzr_pkg::TIME_W'(tgzr_pkg::DEBOUNCE_RST);
         tap_sq_ff      <= tgzr_pkg::TAP_SQ_W'(tgzr_pkg::TAP_DISP_RST * tgzr_pkg::TAP_DISP_RST);
         swipe_min_ff   <= tgzr_pkg::PIX_W'(tgzr_pkg::SWIPE_MIN_RST);
         swipe_cross_ff <= tgzr_pkg::PIX_W'(tgzr_pkg::SWIPE_CROSS_RST);
      end else if (csr_we) begin
         unique case (tgzr_pkg::csr_index_type'(csr_index))
            tgzr_pkg::CSR_TAP_MAX:     tap_max_ff     <= csr_data;
            tgzr_pkg::CSR_HOLD_TIME:   hold_time_ff   <= csr_data;
            tgzr_pkg::CSR_SWIPE_MAX:   swipe_max_ff   <= csr_data;
            tgzr_pkg::CSR_REPEAT_WIN:  repeat_win_ff  <= csr_data;
            tgzr_pkg::CSR_DEBOUNCE:    debounce_ff    <= csr_data;
            tgzr_pkg::CSR_TAP_DISP:    tap_sq_ff      <= tgzr_pkg::TAP_SQ_W'(csr_pix)
                                                         * tgzr_pkg::TAP_SQ_W'(csr_pix);
            tgzr_pkg::CSR_SWIPE_MIN:   swipe_min_ff   <= csr_pix;
            tgzr_pkg::CSR_SWIPE_CROSS: swipe_cross_ff <= csr_pix;
            default: ;
         endcase
      end
   end

   // ---------------- sample register ----------------
   logic [tgzr_pkg::COORD_W-1:0] map_x, map_y;
   tgzr_pkg::zone_type           map_zone;

   logic                          s1_valid_ff;
   logic                          s1_touched_ff;
   logic [tgzr_pkg::COORD_W-1:0]  s1_x_ff, s1_y_ff;
   tgzr_pkg::zone_type            s1_zone_ff;
   logic [tgzr_pkg::STAMP_W-1:0]  s1_stamp_ff;

   logic rsp_valid_ff;
   logic out_free;
   logic fire;

   // Clamp to the panel edge, then rotate by half a turn
   always_comb begin
      if (req.raw_x >= tgzr_pkg::RAW_W'(tgzr_pkg::SCREEN_SIZE)) begin
         map_x = '0;
      end else begin
         map_x = tgzr_pkg::COORD_W'(tgzr_pkg::MAX_COORD) - req.raw_x[tgzr_pkg::COORD_W-1:0];
      end
      if (req.raw_y >= tgzr_pkg::RAW_W'(tgzr_pkg::SCREEN_SIZE)) begin
         map_y = '0;
      end else begin
         map_y = tgzr_pkg::COORD_W'(tgzr_pkg::MAX_COORD) - req.raw_y[tgzr_pkg::COORD_W-1:0];
      end
   end

   tgzr_zone u_zone (
      .pos_x (map_x),
      .pos_y (map_y),
      .zone  (map_zone)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_touched_ff <= req.touched;
         s1_x_ff       <= map_x;
         s1_y_ff       <= map_y;
         s1_zone_ff    <= map_zone;
         s1_stamp_ff   <= req.stamp_us;
      end
   end

   // ---------------- press tracking state ----------------
   logic held_ff, held_in;
   logic long_fired_ff, long_fired_in;
   logic tap_valid_ff, tap_valid_in;
   logic event_valid_ff, event_valid_in;
   tgzr_pkg::zone_type tap_zone_ff, tap_zone_in;
   tgzr_pkg::zone_type start_zone_ff, start_zone_in;
   logic [tgzr_pkg::COORD_W-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [tgzr_pkg::COORD_W-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [tgzr_pkg::STAMP_W-1:0] press_stamp_ff, press_stamp_in;
   logic [tgzr_pkg::STAMP_W-1:0] tap_stamp_ff, tap_stamp_in;
   logic [tgzr_pkg::STAMP_W-1:0] event_stamp_ff, event_stamp_in;

   logic rsp_valid_in;
   tgzr_pkg::gesture_type rsp_gesture_ff, rsp_gesture_in;
   tgzr_pkg::zone_type    rsp_zone_ff, rsp_zone_in;

   // Press start as seen by this sample (a touch-down starts here)
   logic [tgzr_pkg::COORD_W-1:0] eff_start_x, eff_start_y, cur_x, cur_y;
   logic [tgzr_pkg::STAMP_W-1:0] eff_press, dur, since_tap, since_event;
   tgzr_pkg::zone_type           eff_zone;
   logic                         eff_long;

   logic signed [tgzr_pkg::OFS_W-1:0] dx, dy;
   logic signed [tgzr_pkg::SQ_W-1:0]  dx_sq, dy_sq;
   logic [tgzr_pkg::DISP_W-1:0]       disp_sq;
   logic [tgzr_pkg::PIX_W-1:0]        adx, ady;
   logic signed [tgzr_pkg::OFS_W-1:0] smin_pos, smin_neg;
   logic                              stationary;
   logic                              sw_up, sw_down, sw_left, sw_right, sw_time;

   logic                  cand_valid;
   tgzr_pkg::gesture_type cand_gesture;
   logic                  debounced;
   logic                  emit;

   assign eff_start_x = held_ff ? start_x_ff : s1_x_ff;
   assign eff_start_y = held_ff ? start_y_ff : s1_y_ff;
   assign eff_press   = held_ff ? press_stamp_ff : s1_stamp_ff;
   assign eff_zone    = held_ff ? start_zone_ff : s1_zone_ff;
   assign eff_long    = held_ff && long_fired_ff;
   assign cur_x       = s1_touched_ff ? s1_x_ff : last_x_ff;
   assign cur_y       = s1_touched_ff ? s1_y_ff : last_y_ff;

   assign dur         = s1_stamp_ff - eff_press;
   assign since_tap   = s1_stamp_ff - tap_stamp_ff;
   assign since_event = s1_stamp_ff - event_stamp_ff;

   assign dx      = $signed({2'b00, cur_x}) - $signed({2'b00, eff_start_x});
   assign dy      = $signed({2'b00, cur_y}) - $signed({2'b00, eff_start_y});
   assign dx_sq   = tgzr_pkg::SQ_W'(dx) * tgzr_pkg::SQ_W'(dx);
   assign dy_sq   = tgzr_pkg::SQ_W'(dy) * tgzr_pkg::SQ_W'(dy);
   assign disp_sq = tgzr_pkg::DISP_W'(dx_sq) + tgzr_pkg::DISP_W'(dy_sq);
   assign stationary = disp_sq < {1'b0, tap_sq_ff};

   assign adx = dx[tgzr_pkg::OFS_W-1] ? tgzr_pkg::PIX_W'(-dx) : tgzr_pkg::PIX_W'(dx);
   assign ady = dy[tgzr_pkg::OFS_W-1] ? tgzr_pkg::PIX_W'(-dy) : tgzr_pkg::PIX_W'(dy);
   assign smin_pos = $signed({2'b00, swipe_min_ff});
   assign smin_neg = -smin_pos;

   assign sw_time  = dur < {8'b0, swipe_max_ff};
   assign sw_up    = dy < smin_neg && adx < swipe_cross_ff;
   assign sw_down  = dy > smin_pos && adx < swipe_cross_ff;
   assign sw_left  = dx < smin_neg && ady < swipe_cross_ff;
   assign sw_right = dx > smin_pos && ady < swipe_cross_ff;

   assign debounced = event_valid_ff && since_event < {8'b0, debounce_ff};

   always_comb begin
      held_in        = held_ff;
      long_fired_in  = long_fired_ff;
      tap_valid_in   = tap_valid_ff;
      tap_zone_in    = tap_zone_ff;
      tap_stamp_in   = tap_stamp_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      start_zone_in  = start_zone_ff;
      press_stamp_in = press_stamp_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      cand_valid     = 1'b0;
      cand_gesture   = tgzr_pkg::GEST_TAP;

      if (fire) begin
         if (s1_touched_ff) begin
            held_in        = 1'b1;
            start_x_in     = eff_start_x;
            start_y_in     = eff_start_y;
            start_zone_in  = eff_zone;
            press_stamp_in = eff_press;
            long_fired_in  = eff_long;
            last_x_in      = s1_x_ff;
            last_y_in      = s1_y_ff;
            if (!eff_long && dur >= {8'b0, hold_time_ff} && stationary) begin
               long_fired_in = 1'b1;
               cand_valid    = 1'b1;
               cand_gesture  = tgzr_pkg::GEST_LONG;
            end
         end else if (held_ff) begin
            held_in = 1'b0;
            if (!long_fired_ff) begin
               if (sw_time && sw_up) begin
                  cand_valid   = 1'b1;
                  cand_gesture = tgzr_pkg::GEST_UP;
               end else if (sw_time && sw_down) begin
                  cand_valid   = 1'b1;
                  cand_gesture = tgzr_pkg::GEST_DOWN;
               end else if (sw_time && sw_left) begin
                  cand_valid   = 1'b1;
                  cand_gesture = tgzr_pkg::GEST_LEFT;
               end else if (sw_time && sw_right) begin
                  cand_valid   = 1'b1;
                  cand_gesture = tgzr_pkg::GEST_RIGHT;
               end else if (dur < {8'b0, tap_max_ff} && stationary) begin
                  cand_valid = 1'b1;
                  if (tap_valid_ff && since_tap < {8'b0, repeat_win_ff}
                      && tap_zone_ff == start_zone_ff) begin
                     cand_gesture = tgzr_pkg::GEST_DOUBLE;
                     tap_valid_in = 1'b0;
                     tap_zone_in  = tgzr_pkg::ZONE_OUTSIDE;
                  end else begin
                     // tap is remembered even if debounce drops it
                     cand_gesture = tgzr_pkg::GEST_TAP;
                     tap_valid_in = 1'b1;
                     tap_zone_in  = start_zone_ff;
                     tap_stamp_in = s1_stamp_ff;
                  end
               end
            end
         end
      end
   end

   // Debounce stamp moves even when the zone is outside and nothing is sent
   always_comb begin
      event_valid_in = event_valid_ff;
      event_stamp_in = event_stamp_ff;
      emit           = 1'b0;
      if (cand_valid && !debounced) begin
         event_valid_in = 1'b1;
         event_stamp_in = s1_stamp_ff;
         emit           = eff_zone != tgzr_pkg::ZONE_OUTSIDE;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_gesture_in = rsp_gesture_ff;
      rsp_zone_in    = rsp_zone_ff;
      if (fire) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_gesture_in = cand_gesture;
            rsp_zone_in    = eff_zone;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= 1'b0;
         long_fired_ff  <= 1'b0;
         tap_valid_ff   <= 1'b0;
         event_valid_ff <= 1'b0;
         tap_zone_ff    <= tgzr_pkg::ZONE_OUTSIDE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         held_ff        <= held_in;
         long_fired_ff  <= long_fired_in;
         tap_valid_ff   <= tap_valid_in;
         event_valid_ff <= event_valid_in;
         tap_zone_ff    <= tap_zone_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_x_ff     <= start_x_in;
      start_y_ff     <= start_y_in;
      start_zone_ff  <= start_zone_in;
      last_x_ff      <= last_x_in;
      last_y_ff      <= last_y_in;
      press_stamp_ff <= press_stamp_in;
      tap_stamp_ff   <= tap_stamp_in;
      event_stamp_ff <= event_stamp_in;
      rsp_gesture_ff <= rsp_gesture_in;
      rsp_zone_ff    <= rsp_zone_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.gesture = rsp_gesture_ff;
   assign rsp.zone    = rsp_zone_ff;

   // ---------------- checks ----------------
   a_no_outside_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_zone_ff != tgzr_pkg::ZONE_OUTSIDE)
      else $error("result carries the outside zone");

   a_silent_sample_clears_slot: assert property (@(posedge clock) disable iff (reset)
      fire && !emit |=> !rsp_valid_ff)
      else $error("result slot not cleared after a sample without result");

   a_long_while_held: assert property (@(posedge clock) disable iff (reset)
      fire && cand_valid && cand_gesture == tgzr_pkg::GEST_LONG |=> held_ff && long_fired_ff)
      else $error("long press without a held press");

   a_debounce_stamp: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> event_valid_ff && event_stamp_ff == $past(s1_stamp_ff))
      else $error("sent gesture did not update the debounce stamp");

   a_double_clears_tap: assert property (@(posedge clock) disable iff (reset)
      fire && cand_valid && cand_gesture == tgzr_pkg::GEST_DOUBLE
      |=> !tap_valid_ff && tap_zone_ff == tgzr_pkg::ZONE_OUTSIDE)
      else $error("double tap left the tap record set");

endmodule

`default_nettype wire
